### sv/chash_pkg.sv
// ----------------------------------------------------------------------------
// chash_pkg
// Shared types and constants of the chained hash table: operation and status
// codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package chash_pkg;

	localparam int unsigned BUCKETS_DEF = 10;
	localparam int unsigned NODES_DEF   = 64;

	localparam int unsigned KEY_W    = 32;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned BKT_W    = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_SEARCH = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_SPARE  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_DELETED   = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

endpackage

### sv/chained_hash_table.sv
// ----------------------------------------------------------------------------
// chained_hash_table
// Hash table with separate chaining over a fixed node pool; insert, search
// and delete of signed 32-bit keys, one result beat per request beat.
// ----------------------------------------------------------------------------
// After reset the bucket head RAM is swept clear, and no request is taken
// during the sweep. Each request is then accepted, passes the bucket index
// unit (key register, reciprocal multiply, remainder, sign fix), reads the
// head RAM, walks the chain in the node RAM (one node a cycle, set by its
// single read port), pops the free list or frees a deleted node where an
// insert or delete needs it, and hands the result to the output register.
// That last step waits while an earlier result beat is still untaken.
// Inserts do not walk. The node pool is handed out from a free list threaded
// through the node RAM links while that list holds a node, else from a fill
// counter. A new request is taken while a result beat waits.
// ----------------------------------------------------------------------------
module chained_hash_table
	import chash_pkg::*;
#(
	parameter int unsigned BUCKETS = BUCKETS_DEF,
	parameter int unsigned NODES   = NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // key[31:0]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // status[2:0], bucket[6:3], collision[7]
);

	localparam int unsigned BW = $clog2(BUCKETS);
	localparam int unsigned NW = $clog2(NODES);
	localparam int unsigned HW = NW + 1;
	localparam int unsigned FW = $clog2(NODES + 1);
	localparam int unsigned EW = KEY_W + HW;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_MOD   = 8'b0000_0100,
		S_HEAD  = 8'b0000_1000,
		S_ALLOC = 8'b0001_0000,
		S_WALK  = 8'b0010_0000,
		S_FREE  = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic [BW-1:0]    clr_q;
	kind_t            kind_q;
	logic [KEY_W-1:0] key_q;
	logic [BW-1:0]    bkt_q;
	logic [HW-1:0]    head_q;
	logic [NW-1:0]    n_q;
	logic [NW-1:0]    cur_q;
	logic [NW-1:0]    prev_q;
	logic             prev_v_q;
	logic [KEY_W-1:0] prev_key_q;
	logic [HW-1:0]    free_head_q;
	logic [FW-1:0]    fresh_q;
	status_t          res_status_q;
	logic             res_coll_q;
	logic             m_valid_q;
	logic [7:0]       m_data_q;

	logic             mod_done;
	logic [BW-1:0]    mod_res;

	logic             h_we;
	logic [BW-1:0]    h_waddr;
	logic [HW-1:0]    h_wdata;
	logic [BW-1:0]    h_raddr;
	logic [HW-1:0]    h_rdata;

	logic             n_we;
	logic [NW-1:0]    n_waddr;
	logic [EW-1:0]    n_wdata;
	logic [NW-1:0]    n_raddr;
	logic [EW-1:0]    n_rdata;

	logic [KEY_W-1:0] nd_key;
	logic [HW-1:0]    nd_link;
	logic             accept;
	logic             fin_go;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign fin_go   = (state_q == S_FIN) && (!m_valid_q || m_tready);
	assign nd_key   = n_rdata[EW-1:HW];
	assign nd_link  = n_rdata[HW-1:0];

	chash_mod #(
		.BUCKETS(BUCKETS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (s_tdata),
		.done   (mod_done),
		.res    (mod_res)
	);

	chash_ram #(
		.DEPTH(BUCKETS),
		.WIDTH(HW)
	) u_heads (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	chash_ram #(
		.DEPTH(NODES),
		.WIDTH(EW)
	) u_nodes (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	// memory port steering
	always_comb begin
		h_we    = 1'b0;
		h_waddr = bkt_q;
		h_wdata = '0;
		h_raddr = mod_res;
		n_we    = 1'b0;
		n_waddr = cur_q;
		n_wdata = {key_q, free_head_q};
		n_raddr = nd_link[NW-1:0];
		case (state_q)
			S_CLEAR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
			end
			S_HEAD: begin
				if (kind_q == KIND_INSERT) begin
					n_raddr = free_head_q[NW-1:0];
					if (!free_head_q[HW-1] && (fresh_q < FW'(NODES))) begin
						h_we    = 1'b1;
						h_wdata = {1'b1, fresh_q[NW-1:0]};
						n_we    = 1'b1;
						n_waddr = fresh_q[NW-1:0];
						n_wdata = {key_q, h_rdata};
					end
				end else begin
					n_raddr = h_rdata[NW-1:0];
				end
			end
			S_ALLOC: begin
				h_we    = 1'b1;
				h_wdata = {1'b1, n_q};
				n_we    = 1'b1;
				n_waddr = n_q;
				n_wdata = {key_q, head_q};
			end
			S_WALK: begin
				if ((nd_key == key_q) && (kind_q == KIND_DELETE)) begin
					if (prev_v_q) begin
						n_we    = 1'b1;
						n_waddr = prev_q;
						n_wdata = {prev_key_q, nd_link};
					end else begin
						h_we    = 1'b1;
						h_wdata = nd_link;
					end
				end
			end
			S_FREE: begin
				n_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			free_head_q <= '0;
			fresh_q     <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (fin_go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					if (kind_q == KIND_INSERT) begin
						if (free_head_q[HW-1]) begin
							state_q <= S_ALLOC;
						end else begin
							if (fresh_q < FW'(NODES)) begin
								fresh_q <= fresh_q + FW'(1);
							end
							state_q <= S_FIN;
						end
					end else if (h_rdata[HW-1]) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_ALLOC: begin
					free_head_q <= nd_link;
					state_q     <= S_FIN;
				end
				S_WALK: begin
					if (nd_key == key_q) begin
						state_q <= (kind_q == KIND_DELETE) ? S_FREE : S_FIN;
					end else if (!nd_link[HW-1]) begin
						state_q <= S_FIN;
					end
				end
				S_FREE: begin
					free_head_q <= {1'b1, cur_q};
					state_q     <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(s_tuser);
			key_q  <= s_tdata;
		end
		if ((state_q == S_MOD) && mod_done) begin
			bkt_q <= mod_res;
		end
		if (fin_go) begin
			m_data_q <= {res_coll_q, BKT_W'(bkt_q), res_status_q};
		end
		case (state_q)
			S_HEAD: begin
				head_q     <= h_rdata;
				n_q        <= free_head_q[NW-1:0];
				cur_q      <= h_rdata[NW-1:0];
				prev_v_q   <= 1'b0;
				res_coll_q <= 1'b0;
				if (kind_q == KIND_INSERT) begin
					if (!free_head_q[HW-1]) begin
						if (fresh_q < FW'(NODES)) begin
							res_status_q <= ST_INSERTED;
							res_coll_q   <= h_rdata[HW-1];
						end else begin
							res_status_q <= ST_FULL;
						end
					end
				end else begin
					res_status_q <= ST_EMPTY;
				end
			end
			S_ALLOC: begin
				res_status_q <= ST_INSERTED;
				res_coll_q   <= head_q[HW-1];
			end
			S_WALK: begin
				if (nd_key == key_q) begin
					res_status_q <= ST_FOUND;
				end else begin
					res_status_q <= ST_NOT_FOUND;
					prev_q       <= cur_q;
					prev_v_q     <= 1'b1;
					prev_key_q   <= nd_key;
					cur_q        <= nd_link[NW-1:0];
				end
			end
			S_FREE: begin
				res_status_q <= ST_DELETED;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= FW'(NODES))
		else $error("fill counter beyond pool size");

	a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == S_MOD))
		else $error("bucket index ready outside index state");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && m_valid_q && !m_tready) |=> (state_q == S_FIN))
		else $error("result loaded over an untaken beat");

	a_no_node_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		n_we |-> ((state_q != S_IDLE) && (state_q != S_CLEAR)))
		else $error("node ram written outside a request");

endmodule

### sv/chash_ram.sv
// ----------------------------------------------------------------------------
// chash_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module chash_ram
	import chash_pkg::*;
#(
	parameter int unsigned DEPTH = NODES_DEF,
	parameter int unsigned WIDTH = KEY_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/chash_mod.sv
// ----------------------------------------------------------------------------
// chash_mod
// Bucket index unit: signed 32-bit key modulo the bucket count, taken
// non-negative. Quotient by reciprocal multiplication, remainder from its low
// bits, then a sign correction.
// ----------------------------------------------------------------------------
module chash_mod
	import chash_pkg::*;
#(
	parameter int unsigned BUCKETS = BUCKETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [KEY_W-1:0]           key,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] res
);

	localparam int unsigned BW    = $clog2(BUCKETS);
	localparam int unsigned RW    = BW + 1;
	localparam int unsigned MW    = KEY_W + 1;
	localparam int unsigned PW    = KEY_W + MW;
	localparam int unsigned SH    = KEY_W + BW;
	localparam logic [63:0] RECIP = ((64'd1 << SH) / 64'(BUCKETS)) + 64'd1;
	localparam int unsigned CMOD  = int'(64'h1_0000_0000 % 64'(BUCKETS));

	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic             done_q;
	logic [KEY_W-1:0] key_s1;
	logic             neg_s1;
	logic [RW-1:0]    quo_s2;
	logic [RW-1:0]    rem_s3;
	logic [BW-1:0]    res_q;
	logic [PW-1:0]    prod;
	logic [RW-1:0]    rem_nxt;
	logic [RW-1:0]    fix_val;

	// quotient of the unsigned key, only its low bits are kept
	assign prod = PW'(key_s1) * PW'(RECIP[MW-1:0]);

	// remainder is below the bucket count, so the low bits are exact
	assign rem_nxt = key_s1[RW-1:0] - quo_s2 * RW'(BUCKETS);

	// negative key: subtract 2^32 mod buckets
	always_comb begin
		fix_val = rem_s3;
		if (neg_s1) begin
			if (rem_s3 >= RW'(CMOD)) begin
				fix_val = rem_s3 - RW'(CMOD);
			end else begin
				fix_val = rem_s3 + RW'(BUCKETS - CMOD);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_s1 <= key;
			neg_s1 <= key[KEY_W-1];
		end
		if (v_s1) begin
			quo_s2 <= prod[SH +: RW];
		end
		if (v_s2) begin
			rem_s3 <= rem_nxt;
		end
		if (v_s3) begin
			res_q <= fix_val[BW-1:0];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
